### rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and keyword helpers for the scene text
// tokenizer: token record, scan modes, keyword matcher and queue sizing.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int OFFSET_BITS      = 32;
    localparam int LINE_BITS        = 24;
    localparam int KIND_BITS        = 5;
    localparam int FIELD_BITS       = KIND_BITS + 2 * LINE_BITS + 2 * OFFSET_BITS;
    localparam int TDATA_BITS       = ((FIELD_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [7:0]             char_t;

    localparam offset_t OFS_MAX = '1;
    localparam line_t   LN_MAX  = '1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_END      = 5'd0,
        KIND_LBRACE   = 5'd1,
        KIND_RBRACE   = 5'd2,
        KIND_LPAREN   = 5'd3,
        KIND_RPAREN   = 5'd4,
        KIND_LBRACKET = 5'd5,
        KIND_RBRACKET = 5'd6,
        KIND_SEMI     = 5'd7,
        KIND_COLON    = 5'd8,
        KIND_COMMA    = 5'd9,
        KIND_EQUAL    = 5'd10,
        KIND_AT       = 5'd11,
        KIND_STRING   = 5'd12,
        KIND_NUMBER   = 5'd13,
        KIND_IDENT    = 5'd14,
        KIND_DEF      = 5'd15,
        KIND_CLASS    = 5'd16,
        KIND_OVER     = 5'd17,
        KIND_UNKNOWN  = 5'd18
    } token_kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_COMMENT    = 4'd1,
        MODE_STRING     = 4'd2,
        MODE_STRING_ESC = 4'd3,
        MODE_MINUS      = 4'd4,
        MODE_INT        = 4'd5,
        MODE_FRAC       = 4'd6,
        MODE_EXP_START  = 4'd7,
        MODE_EXP        = 4'd8,
        MODE_IDENT      = 4'd9
    } scan_mode_t;

    // keyword matcher: one state per matched prefix
    typedef enum logic [3:0] {
        KW_NONE  = 4'd0,
        KW_D     = 4'd1,
        KW_DE    = 4'd2,
        KW_DEF   = 4'd3,
        KW_C     = 4'd4,
        KW_CL    = 4'd5,
        KW_CLA   = 4'd6,
        KW_CLAS  = 4'd7,
        KW_CLASS = 4'd8,
        KW_O     = 4'd9,
        KW_OV    = 4'd10,
        KW_OVE   = 4'd11,
        KW_OVER  = 4'd12
    } kw_state_t;

    typedef struct packed {
        token_kind_t kind;
        line_t       line;
        line_t       column;
        offset_t     offset;
        offset_t     length;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0] num;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    typedef struct packed {
        logic                        not_empty;
        logic                        room;
        logic [QUEUE_LEVEL_BITS-1:0] level;
    } queue_status_t;

    localparam char_t CH_TAB        = 8'h09;
    localparam char_t CH_LF         = 8'h0A;
    localparam char_t CH_CR         = 8'h0D;
    localparam char_t CH_SPACE      = 8'h20;
    localparam char_t CH_DQUOTE     = 8'h22;
    localparam char_t CH_HASH       = 8'h23;
    localparam char_t CH_SQUOTE     = 8'h27;
    localparam char_t CH_LPAREN     = 8'h28;
    localparam char_t CH_RPAREN     = 8'h29;
    localparam char_t CH_PLUS       = 8'h2B;
    localparam char_t CH_COMMA      = 8'h2C;
    localparam char_t CH_MINUS      = 8'h2D;
    localparam char_t CH_DOT        = 8'h2E;
    localparam char_t CH_0          = 8'h30;
    localparam char_t CH_9          = 8'h39;
    localparam char_t CH_COLON      = 8'h3A;
    localparam char_t CH_SEMI       = 8'h3B;
    localparam char_t CH_EQUAL      = 8'h3D;
    localparam char_t CH_AT         = 8'h40;
    localparam char_t CH_UP_A       = 8'h41;
    localparam char_t CH_UP_E       = 8'h45;
    localparam char_t CH_UP_Z       = 8'h5A;
    localparam char_t CH_LBRACKET   = 8'h5B;
    localparam char_t CH_BSLASH     = 8'h5C;
    localparam char_t CH_RBRACKET   = 8'h5D;
    localparam char_t CH_UNDERSCORE = 8'h5F;
    localparam char_t CH_LO_A       = 8'h61;
    localparam char_t CH_LO_C       = 8'h63;
    localparam char_t CH_LO_D       = 8'h64;
    localparam char_t CH_LO_E       = 8'h65;
    localparam char_t CH_LO_F       = 8'h66;
    localparam char_t CH_LO_L       = 8'h6C;
    localparam char_t CH_LO_O       = 8'h6F;
    localparam char_t CH_LO_R       = 8'h72;
    localparam char_t CH_LO_S       = 8'h73;
    localparam char_t CH_LO_V       = 8'h76;
    localparam char_t CH_LO_Z       = 8'h7A;
    localparam char_t CH_LBRACE     = 8'h7B;
    localparam char_t CH_RBRACE     = 8'h7D;

    function automatic logic is_numeral(input char_t ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    function automatic logic is_letter(input char_t ch);
        return ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z))
            || (ch == CH_UNDERSCORE);
    endfunction

    function automatic logic is_ident_char(input char_t ch);
        return is_letter(ch) || is_numeral(ch) || (ch == CH_COLON);
    endfunction

    // KIND_END means the byte is not punctuation
    function automatic token_kind_t punct_kind(input char_t ch);
        token_kind_t k;
        unique case (ch)
            CH_LBRACE:   k = KIND_LBRACE;
            CH_RBRACE:   k = KIND_RBRACE;
            CH_LPAREN:   k = KIND_LPAREN;
            CH_RPAREN:   k = KIND_RPAREN;
            CH_LBRACKET: k = KIND_LBRACKET;
            CH_RBRACKET: k = KIND_RBRACKET;
            CH_SEMI:     k = KIND_SEMI;
            CH_COLON:    k = KIND_COLON;
            CH_COMMA:    k = KIND_COMMA;
            CH_EQUAL:    k = KIND_EQUAL;
            CH_AT:       k = KIND_AT;
            default:     k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic kw_state_t kw_first_state(input char_t ch);
        kw_state_t s;
        unique case (ch)
            CH_LO_D: s = KW_D;
            CH_LO_C: s = KW_C;
            CH_LO_O: s = KW_O;
            default: s = KW_NONE;
        endcase
        return s;
    endfunction

    function automatic kw_state_t kw_step(input kw_state_t s, input char_t ch);
        kw_state_t n;
        unique case (s)
            KW_D:    n = (ch == CH_LO_E) ? KW_DE   : KW_NONE;
            KW_DE:   n = (ch == CH_LO_F) ? KW_DEF  : KW_NONE;
            KW_C:    n = (ch == CH_LO_L) ? KW_CL   : KW_NONE;
            KW_CL:   n = (ch == CH_LO_A) ? KW_CLA  : KW_NONE;
            KW_CLA:  n = (ch == CH_LO_S) ? KW_CLAS : KW_NONE;
            KW_CLAS: n = (ch == CH_LO_S) ? KW_CLASS : KW_NONE;
            KW_O:    n = (ch == CH_LO_V) ? KW_OV   : KW_NONE;
            KW_OV:   n = (ch == CH_LO_E) ? KW_OVE  : KW_NONE;
            KW_OVE:  n = (ch == CH_LO_R) ? KW_OVER : KW_NONE;
            default: n = KW_NONE;
        endcase
        return n;
    endfunction

    function automatic token_kind_t kw_token_kind(input kw_state_t s);
        token_kind_t k;
        unique case (s)
            KW_DEF:   k = KIND_DEF;
            KW_CLASS: k = KIND_CLASS;
            KW_OVER:  k = KIND_OVER;
            default:  k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

### rtl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Front end: takes one text byte per transaction, tracks position and scan
// mode, and hands zero to two finished tokens to the token queue.
// ----------------------------------------------------------------------------
module stt_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  stt_pkg::char_t      text_byte,
    input  logic                end_of_text,
    output stt_pkg::push_t      push
);

    stt_pkg::scan_mode_t mode_reg, mode_next;
    stt_pkg::kw_state_t  kw_reg, kw_next;
    stt_pkg::offset_t    pos_reg, pos_next;
    stt_pkg::line_t      line_reg, line_next;
    stt_pkg::line_t      col_reg, col_next;
    stt_pkg::offset_t    start_ofs_reg, start_ofs_next;
    stt_pkg::line_t      start_line_reg, start_line_next;
    stt_pkg::line_t      start_col_reg, start_col_next;
    logic                quote_single_reg, quote_single_next;

    logic                c_digit;
    logic                c_exp;
    logic                redo;
    logic                string_close;
    logic                idle_path;
    logic                idle_emit;
    stt_pkg::token_kind_t idle_kind;
    stt_pkg::scan_mode_t idle_mode;
    logic                flush_valid;
    stt_pkg::token_t     flush_tok;
    stt_pkg::token_t     idle_tok;
    stt_pkg::token_t     tok_b;
    logic                a_v;
    logic                b_v;
    stt_pkg::offset_t    span_len;

    assign c_digit   = stt_pkg::is_numeral(text_byte);
    assign c_exp     = (text_byte == stt_pkg::CH_LO_E) || (text_byte == stt_pkg::CH_UP_E);
    assign span_len  = (pos_reg >= start_ofs_reg) ? (pos_reg - start_ofs_reg) : '0;
    assign idle_path = !end_of_text && ((mode_reg == stt_pkg::MODE_IDLE) || redo);

    // byte ends the pending token and, unless it closes a string, must be scanned again from idle
    always_comb
    begin
        redo         = 1'b0;
        string_close = 1'b0;
        unique case (mode_reg)
            stt_pkg::MODE_STRING:
                string_close = quote_single_reg ? (text_byte == stt_pkg::CH_SQUOTE)
                                                : (text_byte == stt_pkg::CH_DQUOTE);
            stt_pkg::MODE_MINUS:     redo = !c_digit;
            stt_pkg::MODE_INT:       redo = !c_digit && (text_byte != stt_pkg::CH_DOT) && !c_exp;
            stt_pkg::MODE_FRAC:      redo = !c_digit && !c_exp;
            stt_pkg::MODE_EXP_START: redo = !(c_digit || (text_byte == stt_pkg::CH_PLUS)
                                            || (text_byte == stt_pkg::CH_MINUS));
            stt_pkg::MODE_EXP:       redo = !c_digit;
            stt_pkg::MODE_IDENT:     redo = !stt_pkg::is_ident_char(text_byte);
            default:                 redo = 1'b0;
        endcase
    end

    // classification of a byte seen between tokens
    always_comb
    begin
        idle_mode = stt_pkg::MODE_IDLE;
        idle_emit = 1'b0;
        idle_kind = stt_pkg::KIND_UNKNOWN;
        if ((text_byte == stt_pkg::CH_SPACE) || (text_byte == stt_pkg::CH_TAB)
            || (text_byte == stt_pkg::CH_CR) || (text_byte == stt_pkg::CH_LF))
        begin
            idle_mode = stt_pkg::MODE_IDLE;
        end
        else if (text_byte == stt_pkg::CH_HASH)
        begin
            idle_mode = stt_pkg::MODE_COMMENT;
        end
        else if (stt_pkg::punct_kind(text_byte) != stt_pkg::KIND_END)
        begin
            idle_emit = 1'b1;
            idle_kind = stt_pkg::punct_kind(text_byte);
        end
        else if ((text_byte == stt_pkg::CH_DQUOTE) || (text_byte == stt_pkg::CH_SQUOTE))
        begin
            idle_mode = stt_pkg::MODE_STRING;
        end
        else if (c_digit)
        begin
            idle_mode = stt_pkg::MODE_INT;
        end
        else if (text_byte == stt_pkg::CH_MINUS)
        begin
            idle_mode = stt_pkg::MODE_MINUS;
        end
        else if (stt_pkg::is_letter(text_byte))
        begin
            idle_mode = stt_pkg::MODE_IDENT;
        end
        else
        begin
            idle_emit = 1'b1;
        end
    end

    // pending token of the current mode
    always_comb
    begin
        flush_valid      = 1'b1;
        flush_tok.kind   = stt_pkg::KIND_NUMBER;
        flush_tok.line   = start_line_reg;
        flush_tok.column = start_col_reg;
        flush_tok.offset = start_ofs_reg;
        flush_tok.length = span_len;
        flush_tok.last   = 1'b0;
        unique case (mode_reg) inside
            stt_pkg::MODE_STRING, stt_pkg::MODE_STRING_ESC:
                flush_tok.kind = stt_pkg::KIND_STRING;
            stt_pkg::MODE_MINUS:
            begin
                flush_tok.kind   = stt_pkg::KIND_UNKNOWN;
                flush_tok.length = '0;
            end
            stt_pkg::MODE_INT, stt_pkg::MODE_FRAC, stt_pkg::MODE_EXP_START,
            stt_pkg::MODE_EXP:
                flush_tok.kind = stt_pkg::KIND_NUMBER;
            stt_pkg::MODE_IDENT:
                flush_tok.kind = stt_pkg::kw_token_kind(kw_reg);
            default:
                flush_valid = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next         = mode_reg;
        kw_next           = kw_reg;
        pos_next          = pos_reg;
        line_next         = line_reg;
        col_next          = col_reg;
        start_ofs_next    = start_ofs_reg;
        start_line_next   = start_line_reg;
        start_col_next    = start_col_reg;
        quote_single_next = quote_single_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                mode_next = stt_pkg::MODE_IDLE;
                kw_next   = stt_pkg::KW_NONE;
            end
            else
            begin
                unique case (mode_reg)
                    stt_pkg::MODE_COMMENT:
                        if (text_byte == stt_pkg::CH_LF)
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                        end
                    stt_pkg::MODE_STRING:
                        if (string_close)
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                        end
                        else if (text_byte == stt_pkg::CH_BSLASH)
                        begin
                            mode_next = stt_pkg::MODE_STRING_ESC;
                        end
                    stt_pkg::MODE_STRING_ESC:
                        mode_next = stt_pkg::MODE_STRING;
                    stt_pkg::MODE_MINUS:
                        if (c_digit)
                        begin
                            mode_next = stt_pkg::MODE_INT;
                        end
                    stt_pkg::MODE_INT:
                        if (text_byte == stt_pkg::CH_DOT)
                        begin
                            mode_next = stt_pkg::MODE_FRAC;
                        end
                        else if (c_exp)
                        begin
                            mode_next = stt_pkg::MODE_EXP_START;
                        end
                    stt_pkg::MODE_FRAC:
                        if (c_exp)
                        begin
                            mode_next = stt_pkg::MODE_EXP_START;
                        end
                    stt_pkg::MODE_EXP_START:
                        mode_next = stt_pkg::MODE_EXP;
                    stt_pkg::MODE_IDENT:
                        kw_next = stt_pkg::kw_step(kw_reg, text_byte);
                    default:
                        mode_next = mode_reg;
                endcase

                if (idle_path)
                begin
                    mode_next = idle_mode;
                    kw_next   = (idle_mode == stt_pkg::MODE_IDENT)
                              ? stt_pkg::kw_first_state(text_byte) : stt_pkg::KW_NONE;
                    if (idle_mode == stt_pkg::MODE_STRING)
                    begin
                        // string text starts after the opening quote
                        start_ofs_next    = (pos_reg == stt_pkg::OFS_MAX) ? stt_pkg::OFS_MAX
                                                                          : pos_reg + 1'b1;
                        start_line_next   = line_reg;
                        start_col_next    = col_reg;
                        quote_single_next = (text_byte == stt_pkg::CH_SQUOTE);
                    end
                    else if ((idle_mode == stt_pkg::MODE_INT)
                             || (idle_mode == stt_pkg::MODE_MINUS)
                             || (idle_mode == stt_pkg::MODE_IDENT))
                    begin
                        start_ofs_next  = pos_reg;
                        start_line_next = line_reg;
                        start_col_next  = col_reg;
                    end
                end

                if (text_byte == stt_pkg::CH_LF)
                begin
                    line_next = (line_reg == stt_pkg::LN_MAX) ? line_reg : line_reg + 1'b1;
                    col_next  = stt_pkg::line_t'(1);
                end
                else if (col_reg != stt_pkg::LN_MAX)
                begin
                    col_next = col_reg + 1'b1;
                end
                if (pos_reg != stt_pkg::OFS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    // tokens out
    always_comb
    begin
        idle_tok.kind   = idle_kind;
        idle_tok.line   = line_reg;
        idle_tok.column = col_reg;
        idle_tok.offset = pos_reg;
        idle_tok.length = '0;
        idle_tok.last   = 1'b0;

        a_v   = 1'b0;
        b_v   = 1'b0;
        tok_b = idle_tok;
        if (accept)
        begin
            if (end_of_text)
            begin
                a_v        = flush_valid;
                b_v        = 1'b1;
                tok_b.kind = stt_pkg::KIND_END;
            end
            else
            begin
                a_v = redo || string_close;
                b_v = idle_path && idle_emit;
            end
        end

        push.num = {a_v & b_v, a_v ^ b_v};
        if (a_v)
        begin
            push.tok0      = flush_tok;
            push.tok0.last = !b_v;
            push.tok1      = tok_b;
            push.tok1.last = 1'b1;
        end
        else
        begin
            push.tok0      = tok_b;
            push.tok0.last = 1'b1;
            push.tok1      = tok_b;
            push.tok1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= stt_pkg::MODE_IDLE;
            kw_reg           <= stt_pkg::KW_NONE;
            pos_reg          <= '0;
            line_reg         <= stt_pkg::line_t'(1);
            col_reg          <= stt_pkg::line_t'(1);
            start_ofs_reg    <= '0;
            start_line_reg   <= stt_pkg::line_t'(1);
            start_col_reg    <= stt_pkg::line_t'(1);
            quote_single_reg <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            kw_reg           <= kw_next;
            pos_reg          <= pos_next;
            line_reg         <= line_next;
            col_reg          <= col_next;
            start_ofs_reg    <= start_ofs_next;
            start_line_reg   <= start_line_next;
            start_col_reg    <= start_col_next;
            quote_single_reg <= quote_single_next;
        end
    end

endmodule

### rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Token queue between scanner and output stage: up to two writes and one
// read per cycle, reports room for a full two-token write.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stt_pkg::push_t         push,
    input  logic                   pop,
    output stt_pkg::token_t        head,
    output stt_pkg::queue_status_t status
);

    stt_pkg::token_t                      entries_reg [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::QUEUE_LEVEL_BITS-1:0] level_reg, level_next;
    logic [stt_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + stt_pkg::QUEUE_PTR_BITS'(1);
    assign head         = entries_reg[rd_ptr_reg];

    assign status.level     = level_reg;
    assign status.not_empty = (level_reg != '0);
    assign status.room      = (level_reg <= stt_pkg::QUEUE_LEVEL_BITS'(stt_pkg::QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + stt_pkg::QUEUE_PTR_BITS'(push.num);
        rd_ptr_next = rd_ptr_reg + stt_pkg::QUEUE_PTR_BITS'(pop);
        level_next  = level_reg + stt_pkg::QUEUE_LEVEL_BITS'(push.num)
                    - stt_pkg::QUEUE_LEVEL_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.num == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

### rtl/stt_out.sv
// ----------------------------------------------------------------------------
// stt_out
// Back end: output register that takes tokens from the queue and presents
// them on the master stream, one transaction per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module stt_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stt_pkg::token_t                head,
    input  logic                           not_empty,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stt_pkg::TDATA_BITS-1:0] m_tdata,
    output logic                           m_tlast
);

    logic            valid_reg, valid_next;
    stt_pkg::token_t tok_reg;

    // refill whenever the register is empty or being drained
    assign pop        = not_empty && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    assign m_tvalid = valid_reg;
    assign m_tlast  = tok_reg.last;
    assign m_tdata  = stt_pkg::TDATA_BITS'({tok_reg.length, tok_reg.offset, tok_reg.column,
                                            tok_reg.line, tok_reg.kind});

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tok_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

### rtl/scene_text_tokenizer.sv
// ----------------------------------------------------------------------------
// scene_text_tokenizer
// Streaming lexer for scene description text: bytes in, tokens out.
// ----------------------------------------------------------------------------
// One text byte (or an end marker in s_tuser) is taken per cycle. Each byte
// yields zero, one or two tokens; a token ends on the first byte that does
// not belong to it, so numbers and identifiers appear one byte late and the
// end marker flushes the pending token before the end token. The scanner
// writes tokens into a four-entry queue and accepts a byte whenever at least
// two entries are free; the output register drains one token per cycle
// while m_tready is high, so the input sustains one byte per cycle as long
// as tokens are taken at the output no slower than they are made. Tokens
// cross the queue and the output register. Line, column and offset saturate.
// ----------------------------------------------------------------------------
module scene_text_tokenizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // text_byte
    input  logic                           s_tuser,   // end_of_text
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // token_kind, start_line, start_column, text_offset, text_length, zero pad
    output logic [stt_pkg::TDATA_BITS-1:0] m_tdata,
    output logic                           m_tlast    // last_of_run
);

    logic                   accept;
    logic                   pop;
    stt_pkg::push_t         push;
    stt_pkg::token_t        head;
    stt_pkg::queue_status_t q_status;

    assign s_tready = q_status.room;
    assign accept   = s_tvalid && s_tready;

    stt_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tuser),
        .push        (push)
    );

    stt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    stt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (q_status.not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= stt_pkg::QUEUE_LEVEL_BITS'(stt_pkg::QUEUE_DEPTH))
        else $error("token queue overfilled");

    // an end marker always leaves at least the end token queued
    a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> q_status.not_empty)
        else $error("end token not queued");

    // no transaction pushes more than two tokens
    a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push.num != 2'd3)
        else $error("more than two tokens from one byte");
`endif

endmodule
